### rtl/ipv6ulc_pkg.sv
// ----------------------------------------------------------------------------
// ipv6ulc_pkg
// Shared types, constants and helpers for the IPv6 upper-layer checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6ulc_pkg;

   // configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrInterfaceId = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrHasAddress  = 1'b1;
   localparam int unsigned CsrDataWidth = 64;

   // protocol constants
   localparam logic [15:0] LinkLocalTop    = 16'hfe80;
   localparam logic [15:0] Dhcp6ServerPort = 16'd547;
   localparam logic [15:0] NhIcmpv6        = 16'd58;
   localparam logic [15:0] NhUdp           = 16'd17;
   localparam logic [11:0] UdpHdrBytes     = 12'd8;
   localparam logic [11:0] Ipv6PppBytes    = 12'd42;   // ipv6 header plus ppp protocol field
   localparam logic [11:0] MaxFrame        = 12'd2048;

   // partial sums of up to eight 16-bit terms
   localparam int unsigned PartWidth = 19;
   localparam int unsigned SeedWideWidth = PartWidth + 2;

   typedef struct packed {
      logic        first;
      logic        last;
      logic        half;
      logic [15:0] word;
      logic        is_udp;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
      logic [15:0] dst_port;
      logic [10:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic [15:0] checksum;
      logic [11:0] frame_length;
      logic        too_big;
   } rsp_type;

   typedef struct packed {
      logic [PartWidth-1:0] src;
      logic [PartWidth-1:0] dst;
      logic [PartWidth-1:0] misc;
   } hdr_sum_type;

   // end-around-carry fold of the three pseudo-header partial sums
   function automatic logic [15:0] fold_seed(input hdr_sum_type sums);
      logic [SeedWideWidth-1:0] wide;
      logic [16:0]              once;
      wide = SeedWideWidth'(sums.src) + SeedWideWidth'(sums.dst)
           + SeedWideWidth'(sums.misc);
      once = 17'(wide[15:0]) + 17'(wide[SeedWideWidth-1:16]);
      return once[15:0] + 16'(once[16]);
   endfunction

endpackage

`default_nettype wire

### rtl/ipv6ulc_pseudo_hdr.sv
// ----------------------------------------------------------------------------
// ipv6ulc_pseudo_hdr
// Pseudo-header and udp header partial sums plus frame length for one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6ulc_pseudo_hdr (
   input  wire ipv6ulc_pkg::req_type     req,
   input  wire logic [63:0]              interface_id,
   input  wire logic                     has_address,
   output ipv6ulc_pkg::hdr_sum_type      sums,
   output logic [11:0]                   frame_length
);

   logic [11:0] ul_len;

   always_comb begin
      ul_len = 12'(req.payload_bytes) + (req.is_udp ? ipv6ulc_pkg::UdpHdrBytes : 12'd0);

      sums.src = '0;
      if (has_address) begin
         sums.src = ipv6ulc_pkg::PartWidth'(ipv6ulc_pkg::LinkLocalTop);
         for (int i = 0; i < 4; i++) begin
            sums.src = sums.src + ipv6ulc_pkg::PartWidth'(interface_id[16*i +: 16]);
         end
      end

      sums.dst = '0;
      for (int i = 0; i < 4; i++) begin
         sums.dst = sums.dst + ipv6ulc_pkg::PartWidth'(req.dst_high[16*i +: 16])
                  + ipv6ulc_pkg::PartWidth'(req.dst_low[16*i +: 16]);
      end

      // upper half of the 32-bit length is always zero
      sums.misc = ipv6ulc_pkg::PartWidth'(ul_len);
      if (req.is_udp) begin
         sums.misc = sums.misc + ipv6ulc_pkg::PartWidth'(ipv6ulc_pkg::NhUdp)
                   + ipv6ulc_pkg::PartWidth'(ipv6ulc_pkg::Dhcp6ServerPort)
                   + ipv6ulc_pkg::PartWidth'(req.dst_port)
                   + ipv6ulc_pkg::PartWidth'(ul_len);
      end else begin
         sums.misc = sums.misc + ipv6ulc_pkg::PartWidth'(ipv6ulc_pkg::NhIcmpv6);
      end

      frame_length = ul_len + ipv6ulc_pkg::Ipv6PppBytes;
   end

endmodule

`default_nettype wire

### rtl/ipv6_upper_layer_checksum.sv
// ----------------------------------------------------------------------------
// ipv6_upper_layer_checksum
// Ones-complement checksum over the ipv6 pseudo-header, optional udp header
// and a stream of 16-bit payload words; one result per packet on the last beat.
//
//   channel  | ports                          | direction
//   ---------+--------------------------------+----------
//   request  | req_valid req_ready req_data   | in
//   response | rsp_valid rsp_ready rsp_data   | out
//   csr      | csr_we csr_index csr_wdata     | in
//
// One payload word per cycle unless the response stalls; a result for its last
// beat passes input register, partial sums, seed fold and accumulate in order.
// The end-around-carry accumulate into the running-sum register sets the rate.
// A stalled response freezes the whole pipeline and drops req_ready.
// Synchronous reset clears the configuration, pipeline valids, running sum and frame length.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_upper_layer_checksum (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire ipv6ulc_pkg::req_type                      req_data,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output ipv6ulc_pkg::rsp_type                           rsp_data,
   input  wire logic                                      csr_we,
   input  wire logic [ipv6ulc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [ipv6ulc_pkg::CsrDataWidth-1:0]      csr_wdata
);

   logic advance;

   // configuration
   logic [63:0] interface_id_ff, interface_id_in;
   logic        has_address_ff, has_address_in;

   // stage 0: input register
   logic                 s0_valid_ff, s0_valid_in;
   ipv6ulc_pkg::req_type s0_ff;

   // stage 1: partial sums
   ipv6ulc_pkg::hdr_sum_type sums;
   logic [11:0]              frame_length;
   logic                     s1_valid_ff, s1_valid_in;
   ipv6ulc_pkg::hdr_sum_type s1_sums_ff;
   logic [15:0]              s1_word_ff, s1_word_in;
   logic                     s1_first_ff, s1_last_ff;
   logic [11:0]              s1_frame_ff;

   // stage 2: folded seed
   logic        s2_valid_ff, s2_valid_in;
   logic [15:0] s2_seed_ff, s2_seed_in;
   logic [15:0] s2_word_ff;
   logic        s2_first_ff, s2_last_ff;
   logic [11:0] s2_frame_ff;

   // accumulate and result
   logic [15:0]          running_sum_ff, running_sum_in;
   logic [11:0]          frame_ff, frame_in;
   logic [15:0]          acc_base;
   logic [16:0]          acc_sum;
   logic                 rsp_valid_ff, rsp_valid_in;
   ipv6ulc_pkg::rsp_type rsp_ff, rsp_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      interface_id_in = interface_id_ff;
      has_address_in  = has_address_ff;
      if (csr_we) begin
         case (csr_index)
            ipv6ulc_pkg::CsrInterfaceId: interface_id_in = csr_wdata;
            ipv6ulc_pkg::CsrHasAddress:  has_address_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   ipv6ulc_pseudo_hdr u_pseudo_hdr (
      .req          (s0_ff),
      .interface_id (interface_id_ff),
      .has_address  (has_address_ff),
      .sums         (sums),
      .frame_length (frame_length)
   );

   always_comb begin
      s0_valid_in = advance ? req_valid : s0_valid_ff;
      s1_valid_in = advance ? s0_valid_ff : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

      // only the high byte counts on a short final word
      s1_word_in = (s0_ff.last && s0_ff.half) ? {s0_ff.word[15:8], 8'h00} : s0_ff.word;
      s2_seed_in = ipv6ulc_pkg::fold_seed(s1_sums_ff);

      acc_base = s2_first_ff ? s2_seed_ff : running_sum_ff;
      acc_sum  = 17'(acc_base) + 17'(s2_word_ff);

      running_sum_in = running_sum_ff;
      frame_in       = frame_ff;
      if (advance && s2_valid_ff) begin
         running_sum_in = acc_sum[15:0] + 16'(acc_sum[16]);
         if (s2_first_ff) begin
            frame_in = s2_frame_ff;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance && s2_valid_ff && s2_last_ff) begin
         rsp_valid_in        = 1'b1;
         rsp_in.checksum     = ~running_sum_in;
         rsp_in.frame_length = frame_in;
         rsp_in.too_big      = frame_in > ipv6ulc_pkg::MaxFrame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interface_id_ff <= '0;
         has_address_ff  <= 1'b0;
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         running_sum_ff  <= '0;
         frame_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         interface_id_ff <= interface_id_in;
         has_address_ff  <= has_address_in;
         s0_valid_ff     <= s0_valid_in;
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         running_sum_ff  <= running_sum_in;
         frame_ff        <= frame_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff       <= req_data;
         s1_sums_ff  <= sums;
         s1_word_ff  <= s1_word_in;
         s1_first_ff <= s0_ff.first;
         s1_last_ff  <= s0_ff.last;
         s1_frame_ff <= frame_length;
         s2_seed_ff  <= s2_seed_in;
         s2_word_ff  <= s1_word_ff;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_frame_ff <= s1_frame_ff;
      end
      rsp_ff <= rsp_in;
   end

   // a final beat leaving the pipeline always lands in the response register
   a_last_to_rsp : assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_last_ff |=> rsp_valid_ff)
      else $error("final beat did not produce a response");

   // running sum only moves when the pipeline advances with a beat
   a_sum_frozen : assert property (@(posedge clock) disable iff (reset)
      !(advance && s2_valid_ff) |=> $stable(running_sum_ff) && $stable(frame_ff))
      else $error("running sum changed without a beat");

   // a new response only comes from a final beat
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("response raised without a final beat");

endmodule

`default_nettype wire

### sim/ipv6_upper_layer_checksum_test.sv
// ----------------------------------------------------------------------------
// ipv6_upper_layer_checksum_test
// Drives payload beats into the IPv6 upper-layer checksum block and checks
// every checksum, frame length and too-big flag against a local model of the
// pseudo-header sum. A directed table comes first, then random packets
// (well-formed, truncated and stray beats) under several source address
// settings and with random gaps on the request side and stalls on the
// response side.
// ----------------------------------------------------------------------------

module ipv6_upper_layer_checksum_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QuietLimit = 4000;
   localparam int unsigned BeatsPerPhase = 250;
   localparam int unsigned RandomPhases = 7;

   typedef struct {
      ipv6ulc_pkg::req_type beat;
      bit                   typed;
      ipv6ulc_pkg::rsp_type want;
   } stim_row_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   ipv6ulc_pkg::req_type                  req_data;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   ipv6ulc_pkg::rsp_type                  rsp_data;
   logic                                  csr_we;
   logic [ipv6ulc_pkg::CsrIndexWidth-1:0] csr_index;
   logic [ipv6ulc_pkg::CsrDataWidth-1:0]  csr_wdata;

   // model state and register copies
   logic [15:0]              sum_acc;
   logic [11:0]              frame_len_latched;
   logic [63:0]              cfg_interface_id;
   logic                     cfg_has_address;

   ipv6ulc_pkg::rsp_type     checksums_due[$];
   stim_row_type             directed[$];

   int unsigned              idle_pct;
   int unsigned              stall_pct;
   int unsigned              beats_sent;
   int unsigned              results_seen;
   int unsigned              too_big_seen;
   int unsigned              errors;
   int unsigned              quiet_cycles;

   ipv6_upper_layer_checksum dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

   function automatic logic [15:0] ones_add64(input logic [15:0] a, input logic [63:0] v);
      logic [15:0] acc;
      acc = ones_add(a, v[63:48]);
      acc = ones_add(acc, v[47:32]);
      acc = ones_add(acc, v[31:16]);
      return ones_add(acc, v[15:0]);
   endfunction

   task automatic predict_checksum(input ipv6ulc_pkg::req_type b, output bit produces,
                                   output ipv6ulc_pkg::rsp_type res);
      logic [11:0] ul_len;
      logic [15:0] acc;
      logic [15:0] w;
      if (b.first) begin
         ul_len = 12'(b.payload_bytes) + (b.is_udp ? ipv6ulc_pkg::UdpHdrBytes : 12'd0);
         acc = '0;
         if (cfg_has_address) begin
            acc = ones_add(acc, ipv6ulc_pkg::LinkLocalTop);
            acc = ones_add64(acc, cfg_interface_id);
         end
         acc = ones_add64(acc, b.dst_high);
         acc = ones_add64(acc, b.dst_low);
         // upper half of the 32-bit length is always zero
         acc = ones_add(acc, 16'(ul_len));
         acc = ones_add(acc, b.is_udp ? ipv6ulc_pkg::NhUdp : ipv6ulc_pkg::NhIcmpv6);
         if (b.is_udp) begin
            acc = ones_add(acc, ipv6ulc_pkg::Dhcp6ServerPort);
            acc = ones_add(acc, b.dst_port);
            acc = ones_add(acc, 16'(ul_len));
         end
         sum_acc = acc;
         frame_len_latched = ul_len + ipv6ulc_pkg::Ipv6PppBytes;
      end
      // a half last beat only carries its high byte
      w = (b.last && b.half) ? {b.word[15:8], 8'h00} : b.word;
      sum_acc = ones_add(sum_acc, w);
      produces = b.last;
      res.checksum = ~sum_acc;
      res.frame_length = frame_len_latched;
      res.too_big = (frame_len_latched > ipv6ulc_pkg::MaxFrame);
   endtask

   function automatic ipv6ulc_pkg::req_type mk_beat(input bit first, input bit last,
                                                    input bit half,
                                                    input logic [15:0] word, input bit is_udp,
                                                    input logic [63:0] dst_high,
                                                    input logic [63:0] dst_low,
                                                    input logic [15:0] dst_port,
                                                    input logic [10:0] payload_bytes);
      ipv6ulc_pkg::req_type b;
      b.first = first;
      b.last = last;
      b.half = half;
      b.word = word;
      b.is_udp = is_udp;
      b.dst_high = dst_high;
      b.dst_low = dst_low;
      b.dst_port = dst_port;
      b.payload_bytes = payload_bytes;
      return b;
   endfunction

   function automatic ipv6ulc_pkg::req_type random_beat();
      logic [191:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return bits[$bits(ipv6ulc_pkg::req_type)-1:0];
   endfunction

   task automatic send_beat(input ipv6ulc_pkg::req_type beat, input bit typed,
                            input ipv6ulc_pkg::rsp_type typed_rsp);
      bit                   produces;
      ipv6ulc_pkg::rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      predict_checksum(beat, produces, predicted);
      if (produces)
         checksums_due.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic send_packet();
      ipv6ulc_pkg::req_type head;
      ipv6ulc_pkg::req_type beat;
      int                   nwords;
      int                   cut;
      // stray beat with every field random
      if ($urandom_range(99) < 12) begin
         send_beat(random_beat(), 1'b0, '0);
         return;
      end
      nwords = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      head = random_beat();
      case ($urandom_range(5))
         0: begin
            head.dst_high = '1;
            head.dst_low = '1;
         end
         1: begin
            head.dst_high = '0;
            head.dst_low = '0;
         end
         2: begin
            head.dst_high = {ipv6ulc_pkg::LinkLocalTop, 48'h0};
            head.dst_low = {$urandom, $urandom};
         end
         default: ;
      endcase
      case ($urandom_range(3))
         0: head.payload_bytes = 11'($urandom_range(1990, 2047));
         1: head.payload_bytes = 11'($urandom);
         default: head.payload_bytes = 11'(nwords * 2);
      endcase
      // broken packets: missing first or missing last
      cut = ($urandom_range(99) < 8) ? $urandom_range(1, nwords) : nwords;
      for (int i = 0; i < cut; i++) begin
         beat = (i == 0) ? head : random_beat();
         beat.first = (i == 0) && ($urandom_range(99) >= 5);
         beat.last = (i == nwords - 1);
         beat.half = beat.last ? 1'($urandom_range(1)) : ($urandom_range(99) < 15);
         send_beat(beat, 1'b0, '0);
      end
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid = 1'b0;
      while (checksums_due.size() != 0)
         @(posedge clock);
      // beats with no result may still be in flight; the pipeline holds while a response waits
      repeat (8) begin
         do @(posedge clock); while (!rsp_ready);
      end
   endtask

   task automatic write_csr(input logic [ipv6ulc_pkg::CsrIndexWidth-1:0] index,
                            input logic [ipv6ulc_pkg::CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      if (index == ipv6ulc_pkg::CsrInterfaceId)
         cfg_interface_id = data;
      else
         cfg_has_address = data[0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic note_mismatch(input string field, input int unsigned want, input int unsigned got);
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
   endtask

   // response side: random backpressure
   always @(negedge clock) begin
      if (!reset)
         rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      ipv6ulc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_data.too_big)
            too_big_seen++;
         if (checksums_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got %h", $time, rsp_data);
         end else begin
            want = checksums_due.pop_front();
            if (rsp_data.checksum !== want.checksum)
               note_mismatch("checksum", want.checksum, rsp_data.checksum);
            if (rsp_data.frame_length !== want.frame_length)
               note_mismatch("frame_length", want.frame_length, rsp_data.frame_length);
            if (rsp_data.too_big !== want.too_big)
               note_mismatch("too_big", want.too_big, rsp_data.too_big);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, checksums_due.size());
         $display("ipv6_upper_layer_checksum_test NOT OK");
         $finish;
      end
   end

   initial begin
      logic [63:0] ifid;
      bit          has;
      int unsigned target;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      beats_sent = 0;
      results_seen = 0;
      too_big_seen = 0;
      errors = 0;
      quiet_cycles = 0;
      sum_acc = '0;
      frame_len_latched = '0;
      cfg_interface_id = '0;
      cfg_has_address = 1'b0;

      // directed rows run with the reset register values (no source address)
      directed.push_back('{mk_beat(1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b1, '{16'hffff, 12'd0, 1'b0}});
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b1, '{16'hffc5, 12'd42, 1'b0}});
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'h0000, 1'b1, '0, '0, 16'h0, 11'd0),
                           1'b1, '{16'hfdbb, 12'd50, 1'b0}});
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'hffff, 1'b0, '1, '1, 16'h0,
                                   11'd2047),
                           1'b1, '{16'hf7c6, 12'd2089, 1'b1}});
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'hffff, 1'b1, '1, '1, 16'hffff,
                                   11'd2047),
                           1'b1, '{16'hedbd, 12'd2097, 1'b1}});
      // frame exactly at the limit, then one byte over
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, 16'h0,
                                   11'd2006),
                           1'b1, '{16'hf7ef, 12'd2048, 1'b0}});
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, '0, '0, 16'h0,
                                   11'd2007),
                           1'b1, '{16'hf7ee, 12'd2049, 1'b1}});
      // echo reply with an odd length
      directed.push_back('{mk_beat(1'b1, 1'b0, 1'b0, 16'h8100, 1'b0, 64'hfe80_0000_0000_0000,
                                   64'h0000_0000_0000_0001, 16'h0, 11'd5), 1'b0, '0});
      directed.push_back('{mk_beat(1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      directed.push_back('{mk_beat(1'b0, 1'b1, 1'b1, 16'habcd, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      // half flag on beats that are not last
      directed.push_back('{mk_beat(1'b1, 1'b0, 1'b1, 16'h5a5a, 1'b1, 64'hff02_0000_0000_0000,
                                   64'h0000_0000_0001_0002, 16'd546, 11'd4), 1'b0, '0});
      directed.push_back('{mk_beat(1'b0, 1'b0, 1'b1, 16'ha5a5, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      directed.push_back('{mk_beat(1'b0, 1'b1, 1'b0, 16'h1234, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      // beats without a first pile onto the previous sum
      directed.push_back('{mk_beat(1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      directed.push_back('{mk_beat(1'b0, 1'b1, 1'b1, 16'hffff, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b1, 16'hffff, 1'b1, 64'h0123_4567_89ab_cdef,
                                   64'hfedc_ba98_7654_3210, 16'hffff, 11'd1), 1'b0, '0});
      // byte count that does not match the beats given
      directed.push_back('{mk_beat(1'b1, 1'b0, 1'b0, 16'h0102, 1'b0, 64'hfe80_0000_0000_0000,
                                   64'h0211_22ff_fe33_4455, 16'h0, 11'd2047), 1'b0, '0});
      directed.push_back('{mk_beat(1'b0, 1'b1, 1'b0, 16'h0304, 1'b0, '0, '0, 16'h0, 11'd0),
                           1'b0, '0});
      // empty udp payload
      directed.push_back('{mk_beat(1'b1, 1'b1, 1'b0, 16'h0000, 1'b1, 64'hfe80_0000_0000_0000,
                                   64'h0000_0000_0000_0002, 16'd546, 11'd0), 1'b0, '0});

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[k])
         send_beat(directed[k].beat, directed[k].typed, directed[k].want);
      drain_pipeline();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         ifid = {$urandom, $urandom};
         has = 1'b1;
         case (phase)
            0: ifid = '0;
            1: ifid = '1;
            2: has = 1'b0;
            4: ifid = 64'h8000_0000_0000_0001;
            6: begin
               ifid = '1;
               has = 1'b0;
            end
            default: ;
         endcase
         write_csr(ipv6ulc_pkg::CsrInterfaceId, ifid);
         write_csr(ipv6ulc_pkg::CsrHasAddress, {31'($urandom), 32'($urandom), has});
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 63;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 63;
            end
            default: begin
               idle_pct = 20;
               stall_pct = 20;
            end
         endcase
         target = beats_sent + BeatsPerPhase;
         while (beats_sent < target)
            send_packet();
         drain_pipeline();
      end

      $display("covered %0d request beats (directed table plus %0d random phases)",
               beats_sent, RandomPhases);
      $display("checked %0d checksums, %0d of them flagged too big, %0d mismatches",
               results_seen, too_big_seen, errors);
      if (errors == 0)
         $display("ipv6_upper_layer_checksum_test OK");
      else
         $display("ipv6_upper_layer_checksum_test NOT OK");
      $finish;
   end

endmodule

### ipv6_upper_layer_checksum.f
rtl/ipv6ulc_pkg.sv
rtl/ipv6ulc_pseudo_hdr.sv
rtl/ipv6_upper_layer_checksum.sv
sim/ipv6_upper_layer_checksum_test.sv
